// ----- rtl/bmpu_pkg.sv -----
// Package for the nearest-neighbor upscaler: sizes, result codes,
// configuration register indexes and clamp helpers.
// No dependencies; every other file of the block imports it.
`default_nettype none

package bmpu_pkg;

    // Line buffer geometry.
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WIDTH_W   = COL_W + 1;

    // Field and register widths.
    localparam int SCALE_W  = 7;
    localparam int HEIGHT_W = 16;
    localparam int CH_W     = 8;
    localparam int PIX_W    = 3 * CH_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = HEIGHT_W;

    localparam logic [SCALE_W-1:0] SCALE_MAX = 7'd100;
    localparam logic [CH_W-1:0]    PAD_BYTE  = 8'h00;

    // Result codes.
    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_PAD    = 2'd2,
        KIND_REJECT = 2'd3
    } t_kind;

    // Input operation codes.
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd2;

    // Scale as used: zero acts as one, above the maximum acts as the maximum.
    function automatic logic [SCALE_W-1:0] eff_scale(input logic [SCALE_W-1:0] s);
        logic [SCALE_W-1:0] v;
        if (s == '0) begin
            v = SCALE_W'(1);
        end else if (s > SCALE_MAX) begin
            v = SCALE_MAX;
        end else begin
            v = s;
        end
        return v;
    endfunction

    // Width as used: zero acts as one, above the buffer depth acts as the depth.
    function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] w);
        logic [WIDTH_W-1:0] v;
        if (w == '0) begin
            v = WIDTH_W'(1);
        end else if (w > WIDTH_W'(MAX_WIDTH)) begin
            v = WIDTH_W'(MAX_WIDTH);
        end else begin
            v = w;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bmpu_in_if.sv -----
// Input channel of the upscaler: valid/ready handshake with one
// load-or-tick item as payload. Depends on bmpu_pkg.
`default_nettype none

interface bmpu_in_if
    import bmpu_pkg::*;
();
    logic            valid;
    logic            ready;
    logic            op;
    logic [CH_W-1:0] in_blue;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_red;

    modport source (output valid, output op, output in_blue, output in_green,
                    output in_red, input ready);
    modport sink   (input valid, input op, input in_blue, input in_green,
                    input in_red, output ready);
endinterface

`default_nettype wire

// ----- rtl/bmpu_out_if.sv -----
// Output channel of the upscaler: valid/ready handshake with one
// result item as payload. Depends on bmpu_pkg.
`default_nettype none

interface bmpu_out_if
    import bmpu_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [1:0]      kind;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_red;
    logic            row_end;
    logic            image_end;

    modport source (output valid, output kind, output out_blue, output out_green,
                    output out_red, output row_end, output image_end, input ready);
    modport sink   (input valid, input kind, input out_blue, input out_green,
                    input out_red, input row_end, input image_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/bmp_nearest_upscaler.sv -----
// Top level of the nearest-neighbor upscaler: counters, line buffer memory
// and a two-stage result pipeline. Depends on bmpu_pkg, bmpu_in_if, bmpu_out_if.
//
// Channel   Dir  Handshake          Payload
// i_pix     in   valid/ready        op, in_blue, in_green, in_red
// o_pix     out  valid/ready        kind, out_blue, out_green, out_red,
//                                   row_end, image_end
// i_cfg_*   in   write enable only  index, data (scale, src_width, src_height)
//
// One item per cycle sustained while o_pix takes results; each result passes
// through the registered read port of the line buffer memory and then the
// output register.
// Reset clears all counters and the pipeline; the line buffer is not cleared
// because every entry is loaded before it is read.
// When o_pix stalls, the pipeline holds and i_pix drops ready once both
// stages are full.
`default_nettype none

module bmp_nearest_upscaler
    import bmpu_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    bmpu_in_if.sink              i_pix,
    bmpu_out_if.source           o_pix,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers.
    logic [SCALE_W-1:0]  r_scale;
    logic [WIDTH_W-1:0]  r_src_width;
    logic [HEIGHT_W-1:0] r_src_height;

    // Sequencing state.
    logic                r_emitting,    n_emitting;
    logic [COL_W-1:0]    r_load_col,    n_load_col;
    logic [COL_W-1:0]    r_read_col,    n_read_col;
    logic [SCALE_W-1:0]  r_horiz_rep,   n_horiz_rep;
    logic [SCALE_W-1:0]  r_vert_rep,    n_vert_rep;
    logic [1:0]          r_pad_left,    n_pad_left;
    logic [HEIGHT_W-1:0] r_source_row,  n_source_row;

    // Line buffer and its read port.
    logic [PIX_W-1:0]    r_line_mem [MAX_WIDTH];
    logic [PIX_W-1:0]    r_rd_data;

    // Pipeline stage one (memory read in flight) and output stage.
    logic                r_s1_valid;
    t_kind               r_s1_kind;
    logic                r_s1_row_end;
    logic                r_s1_image_end;
    logic                r_s2_valid;
    t_kind               r_s2_kind;
    logic [PIX_W-1:0]    r_s2_pix;
    logic                r_s2_row_end;
    logic                r_s2_image_end;

    // Per-transfer decisions.
    t_kind               n_kind;
    logic                n_row_end;
    logic                n_image_end;
    logic                wr_en;
    logic                rd_en;
    logic                advance;
    logic                in_xfer;

    // Derived limits.
    logic [SCALE_W-1:0]  lim_scale;
    logic [WIDTH_W-1:0]  lim_width;
    logic [HEIGHT_W-1:0] lim_height;
    logic [1:0]          pad_count;

    assign lim_scale  = eff_scale(r_scale);
    assign lim_width  = eff_width(r_src_width);
    assign lim_height = (r_src_height == '0) ? HEIGHT_W'(1) : r_src_height;
    // Padding of a row of 3-byte pixels to a multiple of 4 equals (width * scale) mod 4.
    assign pad_count  = lim_width[1:0] * lim_scale[1:0];

    // Pipeline flow control.
    assign advance     = !r_s2_valid || o_pix.ready;
    assign i_pix.ready = !r_s1_valid || advance;
    assign in_xfer     = i_pix.valid && i_pix.ready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale      <= SCALE_W'(1);
            r_src_width  <= WIDTH_W'(1);
            r_src_height <= HEIGHT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SCALE:      r_scale      <= i_cfg_data[SCALE_W-1:0];
                CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data[WIDTH_W-1:0];
                CFG_SRC_HEIGHT: r_src_height <= i_cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Next-state logic for one transfer: load, tick, or rejection.
    always_comb begin
        logic [WIDTH_W-1:0]  col_inc;
        logic [SCALE_W-1:0]  rep_inc;
        logic [SCALE_W-1:0]  vrep_inc;
        logic [HEIGHT_W-1:0] row_inc;
        logic                close_row;

        n_emitting   = r_emitting;
        n_load_col   = r_load_col;
        n_read_col   = r_read_col;
        n_horiz_rep  = r_horiz_rep;
        n_vert_rep   = r_vert_rep;
        n_pad_left   = r_pad_left;
        n_source_row = r_source_row;
        n_kind       = KIND_NONE;
        n_row_end    = 1'b0;
        n_image_end  = 1'b0;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        close_row    = 1'b0;

        col_inc  = '0;
        rep_inc  = r_horiz_rep + SCALE_W'(1);
        vrep_inc = r_vert_rep + SCALE_W'(1);
        row_inc  = r_source_row + HEIGHT_W'(1);

        if (i_pix.op == OP_LOAD) begin
            if (r_emitting) begin
                n_kind = KIND_REJECT;
            end else begin
                wr_en   = in_xfer;
                col_inc = {1'b0, r_load_col} + WIDTH_W'(1);
                n_load_col = col_inc[COL_W-1:0];
                if (col_inc >= lim_width) begin
                    n_load_col  = '0;
                    n_read_col  = '0;
                    n_horiz_rep = '0;
                    n_pad_left  = '0;
                    n_emitting  = 1'b1;
                end
            end
        end else if (r_emitting) begin
            if (r_pad_left != 2'd0) begin
                // Padding byte after the last pixel of an output row.
                n_kind     = KIND_PAD;
                n_pad_left = r_pad_left - 2'd1;
                if (r_pad_left == 2'd1) begin
                    close_row = 1'b1;
                end
            end else begin
                // Pixel from the line buffer; data arrives next cycle.
                n_kind      = KIND_PIXEL;
                rd_en       = in_xfer;
                n_horiz_rep = rep_inc;
                if (rep_inc >= lim_scale) begin
                    n_horiz_rep = '0;
                    col_inc     = {1'b0, r_read_col} + WIDTH_W'(1);
                    n_read_col  = col_inc[COL_W-1:0];
                    if (col_inc >= lim_width) begin
                        n_read_col = '0;
                        if (pad_count == 2'd0) begin
                            close_row = 1'b1;
                        end else begin
                            n_pad_left = pad_count;
                        end
                    end
                end
            end
        end

        // End of an output row: count vertical copies and source rows.
        if (close_row) begin
            n_row_end  = 1'b1;
            n_vert_rep = vrep_inc;
            if (vrep_inc >= lim_scale) begin
                n_vert_rep   = '0;
                n_emitting   = 1'b0;
                n_source_row = row_inc;
                if (row_inc >= lim_height || row_inc == '0) begin
                    n_source_row = '0;
                    n_image_end  = 1'b1;
                end
            end
        end
    end

    // Sequencing registers update on every input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emitting   <= 1'b0;
            r_load_col   <= '0;
            r_read_col   <= '0;
            r_horiz_rep  <= '0;
            r_vert_rep   <= '0;
            r_pad_left   <= '0;
            r_source_row <= '0;
        end else if (in_xfer) begin
            r_emitting   <= n_emitting;
            r_load_col   <= n_load_col;
            r_read_col   <= n_read_col;
            r_horiz_rep  <= n_horiz_rep;
            r_vert_rep   <= n_vert_rep;
            r_pad_left   <= n_pad_left;
            r_source_row <= n_source_row;
        end
    end

    // Line buffer: one write port for loads, one registered read port for ticks.
    // Loads and pixel reads never meet in the same cycle, and the emit phase
    // only starts after the last load has been written.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_line_mem[r_load_col] <= {i_pix.in_red, i_pix.in_green, i_pix.in_blue};
        end
        if (rd_en) begin
            r_rd_data <= r_line_mem[r_read_col];
        end
    end

    // Stage one valid and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (i_pix.ready) begin
                r_s1_valid <= i_pix.valid;
            end
            if (advance) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    // Stage payloads; the pixel value is taken from the read port on the move.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_kind      <= n_kind;
            r_s1_row_end   <= n_row_end;
            r_s1_image_end <= n_image_end;
        end
        if (advance && r_s1_valid) begin
            r_s2_kind      <= r_s1_kind;
            r_s2_row_end   <= r_s1_row_end;
            r_s2_image_end <= r_s1_image_end;
            r_s2_pix       <= (r_s1_kind == KIND_PIXEL) ? r_rd_data
                                                        : {3{PAD_BYTE}};
        end
    end

    assign o_pix.valid     = r_s2_valid;
    assign o_pix.kind      = r_s2_kind;
    assign o_pix.out_blue  = r_s2_pix[CH_W-1:0];
    assign o_pix.out_green = r_s2_pix[2*CH_W-1:CH_W];
    assign o_pix.out_red   = r_s2_pix[3*CH_W-1:2*CH_W];
    assign o_pix.row_end   = r_s2_row_end;
    assign o_pix.image_end = r_s2_image_end;

endmodule

`default_nettype wire

// ----- test/tb_bmp_nearest_upscaler.sv -----
// Testbench for bmp_nearest_upscaler: loads source rows, ticks out the enlarged
// rows and checks every result against a cycle-free prediction of the block.
// Depends on bmpu_pkg, bmpu_in_if, bmpu_out_if and the upscaler RTL.

// One result item as the block presents it.
typedef struct packed {
    bmpu_pkg::t_kind kind;
    logic [7:0]      blue;
    logic [7:0]      green;
    logic [7:0]      red;
    logic            row_end;
    logic            image_end;
} t_up_result;

// Tracks the upscaler's line buffer and counters and keeps the results still owed.
class upscale_tracker;
    logic [6:0]  scale_reg;
    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic [23:0] line_buf [bmpu_pkg::MAX_WIDTH];
    bit          emitting;
    int unsigned load_col, read_col, h_rep, v_rep, pad_left, src_row;
    t_up_result  owed_px_q [$];
    int unsigned items_taken, images_done, results_seen, fail_count;

    function new();
        scale_reg  = 7'd1;
        width_reg  = 11'd1;
        height_reg = 16'd1;
        emitting   = 1'b0;
        load_col   = 0;
        read_col   = 0;
        h_rep      = 0;
        v_rep      = 0;
        pad_left   = 0;
        src_row    = 0;
        items_taken  = 0;
        images_done  = 0;
        results_seen = 0;
        fail_count   = 0;
        foreach (line_buf[i]) line_buf[i] = '0;
    endfunction

    // Register values as the block applies them after clamping.
    function int unsigned used_scale();
        if (scale_reg == 0) return 1;
        if (scale_reg > bmpu_pkg::SCALE_MAX) return bmpu_pkg::SCALE_MAX;
        return scale_reg;
    endfunction

    function int unsigned used_width();
        if (width_reg == 0) return 1;
        if (width_reg > bmpu_pkg::MAX_WIDTH) return bmpu_pkg::MAX_WIDTH;
        return width_reg;
    endfunction

    function int unsigned used_height();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
        case (idx)
            bmpu_pkg::CFG_SCALE:      scale_reg  = data[6:0];
            bmpu_pkg::CFG_SRC_WIDTH:  width_reg  = data[10:0];
            bmpu_pkg::CFG_SRC_HEIGHT: height_reg = data[15:0];
            default: ;
        endcase
    endfunction

    // Closes one output row; returns 1 when the image is complete.
    function bit close_row();
        v_rep = (v_rep + 1) & 32'h7F;
        if (v_rep >= used_scale()) begin
            v_rep    = 0;
            emitting = 1'b0;
            src_row  = (src_row + 1) & 32'hFFFF;
            if (src_row >= used_height() || src_row == 0) begin
                src_row = 0;
                images_done++;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Advances the state by one item and returns the result it causes.
    function t_up_result upscale_step(bmpu_pkg::t_op op, logic [23:0] px);
        t_up_result  res;
        int unsigned col;
        int unsigned pad;
        logic [23:0] held;
        res = '0;
        res.kind = bmpu_pkg::KIND_NONE;
        if (op == bmpu_pkg::OP_LOAD) begin
            if (emitting) begin
                res.kind = bmpu_pkg::KIND_REJECT;
            end else begin
                col = (load_col < bmpu_pkg::MAX_WIDTH) ? load_col : 0;
                line_buf[col] = px;
                load_col = col + 1;
                if (load_col >= used_width()) begin
                    load_col = 0;
                    read_col = 0;
                    h_rep    = 0;
                    pad_left = 0;
                    emitting = 1'b1;
                end
            end
        end else if (emitting) begin
            if (pad_left != 0) begin
                res.kind = bmpu_pkg::KIND_PAD;
                pad_left = pad_left - 1;
                if (pad_left == 0) begin
                    res.row_end   = 1'b1;
                    res.image_end = close_row();
                end
            end else begin
                col  = (read_col < bmpu_pkg::MAX_WIDTH) ? read_col : 0;
                held = line_buf[col];
                res.kind  = bmpu_pkg::KIND_PIXEL;
                res.blue  = held[7:0];
                res.green = held[15:8];
                res.red   = held[23:16];
                h_rep = (h_rep + 1) & 32'h7F;
                if (h_rep >= used_scale()) begin
                    h_rep    = 0;
                    read_col = col + 1;
                    if (read_col >= used_width()) begin
                        pad      = (used_width() * used_scale()) % 4;
                        read_col = 0;
                        if (pad == 0) begin
                            res.row_end   = 1'b1;
                            res.image_end = close_row();
                        end else begin
                            pad_left = pad;
                        end
                    end
                end
            end
        end
        return res;
    endfunction

    // Called for every input transfer.
    function void take_item(bmpu_pkg::t_op op, logic [23:0] px);
        owed_px_q.push_back(upscale_step(op, px));
        items_taken++;
    endfunction

    // Called for every output transfer; compares with the oldest owed result.
    function void match_output(t_up_result got);
        t_up_result want;
        results_seen++;
        if (owed_px_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("result %0d arrived with none owed: kind=%0d bgr=%02h/%02h/%02h %s",
                         results_seen, got.kind, got.blue, got.green, got.red,
                         $sformatf("re=%0b ie=%0b", got.row_end, got.image_end));
            return;
        end
        want = owed_px_q.pop_front();
        if (got.kind !== want.kind || got.blue !== want.blue || got.green !== want.green ||
            got.red !== want.red || got.row_end !== want.row_end ||
            got.image_end !== want.image_end) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("result %0d mismatch:", results_seen);
                $display("  expected kind=%0d bgr=%02h/%02h/%02h re=%0b ie=%0b",
                         want.kind, want.blue, want.green, want.red,
                         want.row_end, want.image_end);
                $display("  actual   kind=%0d bgr=%02h/%02h/%02h re=%0b ie=%0b",
                         got.kind, got.blue, got.green, got.red,
                         got.row_end, got.image_end);
            end
        end
    endfunction
endclass

module tb_bmp_nearest_upscaler;
    import bmpu_pkg::*;

    localparam int unsigned ITEM_TARGET  = 1450;
    localparam int unsigned QUIET_LIMIT  = 1000;
    localparam int unsigned SETTLE_GAP   = 4;
    localparam int unsigned HOLD_CYCLES  = 60;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bmpu_in_if  pix_in ();
    bmpu_out_if pix_out ();

    upscale_tracker tracker;
    bit             send_burst;
    int unsigned    quiet_cycles;

    bmp_nearest_upscaler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (pix_in),
        .o_pix       (pix_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if ((pix_in.valid === 1'b1 && pix_in.ready === 1'b1) ||
                (pix_out.valid === 1'b1 && pix_out.ready === 1'b1)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Offers one item, with a random gap first, and waits for its transfer.
    task automatic send_item(input t_op op, input logic [23:0] px);
        int unsigned gap;
        if ($urandom_range(0, 99) < 3) send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_in.valid    <= 1'b1;
        pix_in.op       <= op;
        pix_in.in_blue  <= px[7:0];
        pix_in.in_green <= px[15:8];
        pix_in.in_red   <= px[23:16];
        do @(posedge i_clk); while (!(pix_in.valid === 1'b1 && pix_in.ready === 1'b1));
        tracker.take_item(op, px);
    endtask

    // Stops offering and waits until every owed result has come out.
    task automatic settle();
        pix_in.valid <= 1'b0;
        while (tracker.owed_px_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_GAP) @(posedge i_clk);
    endtask

    // Writes one register; only called with the block drained.
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.write_reg(idx, data);
    endtask

    // New small geometry, written after settling; wide rows keep a low scale.
    task automatic pick_geometry();
        int unsigned w;
        int unsigned s;
        settle();
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 7);
        s = (w > 8) ? $urandom_range(0, 2) : $urandom_range(0, 4);
        write_cfg(CFG_SRC_WIDTH, CFG_DATA_W'(w));
        write_cfg(CFG_SCALE, CFG_DATA_W'(s));
        write_cfg(CFG_SRC_HEIGHT, CFG_DATA_W'($urandom_range(0, 3)));
    endtask

    // Drives loads and ticks as the phase calls for until the image completes,
    // with some wrong-phase items mixed in and an occasional burst of noise.
    task automatic run_image();
        int unsigned start;
        bit          noise;
        t_op         op;
        start = tracker.images_done;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(3, 15)) send_item(t_op'($urandom_range(0, 1)), 24'($urandom));
        end
        while (tracker.images_done == start) begin
            // Scale or height changed mid-image; neither can read an unloaded entry.
            if ($urandom_range(0, 299) == 0) begin
                settle();
                write_cfg($urandom_range(0, 1) ? CFG_SCALE : CFG_SRC_HEIGHT,
                          CFG_DATA_W'($urandom_range(0, 4)));
            end
            noise = ($urandom_range(0, 99) < 8);
            op = (tracker.emitting ^ noise) ? OP_TICK : OP_LOAD;
            send_item(op, 24'($urandom));
        end
    endtask

    // Result side: random stalls, two long hold-offs, one check per transfer.
    initial begin
        int unsigned gap;
        bit          burst;
        t_up_result  got;
        pix_out.ready <= 1'b0;
        burst = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 99) < 3) burst = !burst;
            gap = burst ? 0 : $urandom_range(0, 3);
            if (tracker.results_seen == 300 || tracker.results_seen == 900) gap = HOLD_CYCLES;
            if (gap != 0) begin
                pix_out.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pix_out.ready <= 1'b1;
            do @(posedge i_clk); while (!(pix_out.valid === 1'b1 && pix_out.ready === 1'b1));
            got.kind      = t_kind'(pix_out.kind);
            got.blue      = pix_out.out_blue;
            got.green     = pix_out.out_green;
            got.red       = pix_out.out_red;
            got.row_end   = pix_out.row_end;
            got.image_end = pix_out.image_end;
            tracker.match_output(got);
        end
    end

    // Stimulus: reset, directed cases, then random images.
    initial begin
        tracker      = new();
        send_burst   = 1'b0;
        quiet_cycles = 0;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= CFG_SCALE;
        i_cfg_data      <= '0;
        pix_in.valid    <= 1'b0;
        pix_in.op       <= OP_LOAD;
        pix_in.in_blue  <= '0;
        pix_in.in_green <= '0;
        pix_in.in_red   <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry: tick while loading, load, load rejected while
        // emitting, then the pixel and its single padding byte.
        send_item(OP_TICK, 24'h000000);
        send_item(OP_LOAD, 24'hFFFFFF);
        send_item(OP_LOAD, 24'h123456);
        send_item(OP_TICK, 24'h000000);
        send_item(OP_TICK, 24'hFFFFFF);

        // All-zero registers act as one.
        settle();
        write_cfg(CFG_SCALE, '0);
        write_cfg(CFG_SRC_WIDTH, '0);
        write_cfg(CFG_SRC_HEIGHT, '0);
        send_item(OP_LOAD, 24'h000000);
        send_item(OP_TICK, 24'hFFFFFF);
        send_item(OP_TICK, 24'h000000);

        // Scale above the maximum and the largest height, both cut back
        // in the middle of a row.
        settle();
        write_cfg(CFG_SCALE, CFG_DATA_W'(127));
        write_cfg(CFG_SRC_WIDTH, CFG_DATA_W'(2));
        write_cfg(CFG_SRC_HEIGHT, 16'hFFFF);
        send_item(OP_LOAD, 24'hAA55AA);
        send_item(OP_LOAD, 24'h55AA55);
        repeat (3) send_item(OP_TICK, 24'h000000);
        settle();
        write_cfg(CFG_SCALE, CFG_DATA_W'(2));
        write_cfg(CFG_SRC_HEIGHT, CFG_DATA_W'(1));
        run_image();

        // Width above the buffer depth at the largest scale, narrowed while
        // the row is loading, then scale dropped while emitting.
        settle();
        write_cfg(CFG_SRC_WIDTH, CFG_DATA_W'(2047));
        write_cfg(CFG_SCALE, CFG_DATA_W'(100));
        write_cfg(CFG_SRC_HEIGHT, CFG_DATA_W'(2));
        repeat (4) send_item(OP_LOAD, 24'($urandom));
        settle();
        write_cfg(CFG_SRC_WIDTH, CFG_DATA_W'(3));
        send_item(OP_LOAD, 24'($urandom));
        repeat (3) send_item(OP_TICK, 24'h000000);
        settle();
        write_cfg(CFG_SCALE, CFG_DATA_W'(1));
        run_image();

        // Exact buffer depth, left partly loaded for the next geometry.
        settle();
        write_cfg(CFG_SRC_WIDTH, CFG_DATA_W'(MAX_WIDTH));
        repeat (2) send_item(OP_LOAD, 24'($urandom));

        // Random images.
        pick_geometry();
        while (tracker.items_taken < ITEM_TARGET) begin
            run_image();
            if ($urandom_range(0, 9) < 6) pick_geometry();
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (tracker.fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/bmpu_pkg.sv
rtl/bmpu_in_if.sv
rtl/bmpu_out_if.sv
rtl/bmp_nearest_upscaler.sv
test/tb_bmp_nearest_upscaler.sv
